// ===== rtl/qvcsg_pkg.sv =====
// Shared types, codes and the K=5 rate-1/2 convolution table for the
// QPSK varicode symbol generator. No dependencies.
package qvcsg_pkg;

    localparam int CODEWORD_BITS_DEF = 16;
    localparam int SHIFT_BITS        = 5;
    localparam int SYMBOL_BITS       = 2;
    localparam int ACTION_BITS       = 2;

    localparam logic [ACTION_BITS-1:0] ACT_CHAR   = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_TX_ON  = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_TX_OFF = 2'd2;
    localparam logic [ACTION_BITS-1:0] ACT_IDLE   = 2'd3;

    localparam logic [SYMBOL_BITS-1:0] SYMBOL_ON  = 2'd2;
    localparam logic [SYMBOL_BITS-1:0] SYMBOL_OFF = 2'd0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_BITS,
        ST_END
    } state_t;

    typedef enum logic [1:0] {
        PH_FETCH,
        PH_BITS,
        PH_END
    } phase_t;

    typedef struct packed {
        logic   load;
        logic   step;
        phase_t phase;
    } dp_cmd_t;

    typedef struct packed {
        logic is_char;
        logic pend_zero;
        logic rest_zero;
    } dp_status_t;

    function automatic logic [SYMBOL_BITS-1:0] conv_symbol(input logic [SHIFT_BITS-1:0] idx);
        logic [SYMBOL_BITS-1:0] sym;
        case (idx)
            5'd0:    sym = 2'd2;
            5'd1:    sym = 2'd1;
            5'd2:    sym = 2'd3;
            5'd3:    sym = 2'd0;
            5'd4:    sym = 2'd3;
            5'd5:    sym = 2'd0;
            5'd6:    sym = 2'd2;
            5'd7:    sym = 2'd1;
            5'd8:    sym = 2'd0;
            5'd9:    sym = 2'd3;
            5'd10:   sym = 2'd1;
            5'd11:   sym = 2'd2;
            5'd12:   sym = 2'd1;
            5'd13:   sym = 2'd2;
            5'd14:   sym = 2'd0;
            5'd15:   sym = 2'd3;
            5'd16:   sym = 2'd1;
            5'd17:   sym = 2'd2;
            5'd18:   sym = 2'd0;
            5'd19:   sym = 2'd3;
            5'd20:   sym = 2'd0;
            5'd21:   sym = 2'd3;
            5'd22:   sym = 2'd1;
            5'd23:   sym = 2'd2;
            5'd24:   sym = 2'd3;
            5'd25:   sym = 2'd0;
            5'd26:   sym = 2'd2;
            5'd27:   sym = 2'd1;
            5'd28:   sym = 2'd2;
            5'd29:   sym = 2'd1;
            5'd30:   sym = 2'd3;
            5'd31:   sym = 2'd0;
            default: sym = 2'd0;
        endcase
        return sym;
    endfunction

endpackage

// ===== rtl/qvcsg_datapath.sv =====
// Datapath: item holding registers, encoder shift register, codeword
// shifter and the output symbol register. Depends on qvcsg_pkg.
module qvcsg_datapath
    import qvcsg_pkg::*;
#(
    parameter int CODEWORD_BITS = CODEWORD_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    input  logic [ACTION_BITS-1:0]   action_in,
    input  logic [CODEWORD_BITS-1:0] codeword_in,
    output dp_status_t               status,
    output logic [SYMBOL_BITS-1:0]   symbol,
    output logic                     last
);

    logic [ACTION_BITS-1:0]   action_reg;
    logic [CODEWORD_BITS-1:0] pending_reg, pending_next;
    logic [SHIFT_BITS-1:0]    shift_reg, shift_next;
    logic [SYMBOL_BITS-1:0]   sym_reg, sym_next;
    logic                     last_reg, last_next;
    logic                     is_char;
    logic                     pend_zero;
    logic                     bit_in;

    assign is_char   = (action_reg == ACT_CHAR);
    assign pend_zero = (pending_reg == '0);

    always_comb
    begin
        pending_next = pending_reg;
        sym_next     = sym_reg;
        last_next    = last_reg;
        bit_in       = 1'b0;
        case (cmd.phase)
            PH_FETCH:
            begin
                sym_next = conv_symbol(shift_reg);
                if (action_reg == ACT_TX_ON)
                begin
                    sym_next = SYMBOL_ON;
                end
                else if (action_reg == ACT_TX_OFF)
                begin
                    sym_next = SYMBOL_OFF;
                end
                last_next = !is_char || pend_zero;
            end
            PH_BITS:
            begin
                bit_in       = pending_reg[CODEWORD_BITS-1];
                pending_next = {pending_reg[CODEWORD_BITS-2:0], 1'b0};
                sym_next     = conv_symbol(shift_reg);
                last_next    = 1'b0;
            end
            PH_END:
            begin
                sym_next  = conv_symbol(shift_reg);
                last_next = 1'b1;
            end
            default:
            begin
                sym_next = sym_reg;
            end
        endcase
        shift_next = {shift_reg[SHIFT_BITS-2:0], bit_in};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
        end
        else if (cmd.step)
        begin
            shift_reg <= shift_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg  <= action_in;
            pending_reg <= codeword_in;
        end
        else if (cmd.step)
        begin
            pending_reg <= pending_next;
        end
        if (cmd.step)
        begin
            sym_reg  <= sym_next;
            last_reg <= last_next;
        end
    end

    assign status.is_char   = is_char;
    assign status.pend_zero = pend_zero;
    assign status.rest_zero = (pending_reg[CODEWORD_BITS-2:0] == '0);
    assign symbol           = sym_reg;
    assign last             = last_reg;

endmodule

// ===== rtl/qvcsg_ctrl.sv =====
// Controller: sequences the fetch, codeword-bit and ending-zero symbols
// and owns the input ready and output valid. Depends on qvcsg_pkg.
module qvcsg_ctrl
    import qvcsg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    // The output register can take a new symbol when empty or being drained.
    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        cmd.phase  = PH_FETCH;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.phase = PH_FETCH;
                if (slot_free)
                begin
                    cmd.step   = 1'b1;
                    state_next = (!status.is_char || status.pend_zero) ? ST_IDLE : ST_BITS;
                end
            end
            ST_BITS:
            begin
                cmd.phase = PH_BITS;
                if (slot_free)
                begin
                    cmd.step = 1'b1;
                    // advance to the ending zero once the last set bit leaves
                    if (status.rest_zero)
                    begin
                        state_next = ST_END;
                    end
                end
            end
            ST_END:
            begin
                cmd.phase = PH_END;
                if (slot_free)
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = cmd.step || (out_valid_reg && !out_ready);
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/qpsk_varicode_conv_symbol_gen.sv =====
// Top level of the QPSK varicode symbol generator: joins the controller
// and the datapath. Depends on qvcsg_pkg, qvcsg_ctrl and qvcsg_datapath.
//
// Input channel s_axis: tuser carries the action (character, transmit on,
// transmit off, toggle/idle), tdata the left-aligned varicode codeword.
// Output channel m_axis: tdata carries one 2-bit QPSK symbol, tlast marks
// the final symbol caused by an input item.
// An item is taken while the block is idle; symbols then leave at one
// per cycle, while the receiver accepts them, through a single output
// register, so the first symbol enters that register from the fetch state
// that follows the input transfer. A character item with a nonzero
// codeword of set-bit span n gives n + 2 symbols (at most CODEWORD_BITS + 2);
// other items give one symbol. The symbol sequencer in the controller sets
// these counts. The next input is taken while the final symbol still waits in
// the output register. When the receiver stalls, the symbol is held and the
// sequencer waits. Reset clears the encoder shift register and the output
// valid, and returns the sequencer to idle.
module qpsk_varicode_conv_symbol_gen
    import qvcsg_pkg::*;
#(
    parameter int CODEWORD_BITS = CODEWORD_BITS_DEF,
    localparam int IN_DATA_BITS = ((CODEWORD_BITS + 7) / 8) * 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [IN_DATA_BITS-1:0] s_axis_tdata,   // codeword, zero padding
    input  logic [ACTION_BITS-1:0]  s_axis_tuser,   // action
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [7:0]              m_axis_tdata,   // symbol, zero padding
    output logic                    m_axis_tlast
);

    dp_cmd_t                cmd;
    dp_status_t             status;
    logic [SYMBOL_BITS-1:0] symbol;

    qvcsg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    qvcsg_datapath #(
        .CODEWORD_BITS (CODEWORD_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .action_in   (s_axis_tuser),
        .codeword_in (s_axis_tdata[CODEWORD_BITS-1:0]),
        .status      (status),
        .symbol      (symbol),
        .last        (m_axis_tlast)
    );

    assign m_axis_tdata = {{(8 - SYMBOL_BITS){1'b0}}, symbol};

endmodule
